### hw/rtl/strict_priority_multi_fifo_defines.svh
// Assertion macros used by the checker file of the priority queue block.
`ifndef STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SPMF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("priority queue check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SPMF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("priority queue check failed");

`endif

### hw/rtl/spmf_pkg.sv
// Shared constants, codes and types of the strict priority queue block.
package spmf_pkg;

   // Sizing of the queue
   localparam int LEVELS     = 4;
   localparam int DEPTH      = 16;
   localparam int VALUE_BITS = 32;

   // Fixed field widths of the channels
   localparam int KIND_BITS        = 1;
   localparam int LEVEL_FIELD_BITS = 3;
   localparam int DATA_BITS        = 32;
   localparam int STATUS_BITS      = 2;

   // Derived widths
   localparam int STORE_BITS = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;
   localparam int LEVEL_BITS = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int SLOTS      = LEVELS * DEPTH;
   localparam int ADDR_BITS  = $clog2(SLOTS);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Request kinds
   localparam logic [KIND_BITS-1:0] KIND_PUSH = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_POP  = 1'b1;

   // Result codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // Classified operations handed from front to back
   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_INVALID
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [LEVEL_BITS-1:0] level;
      logic [STORE_BITS-1:0] value;
   } cmd_type;

endpackage

### hw/rtl/spmf_req_if.sv
// Request channel: valid/ready handshake carrying one push or pop transaction.
interface spmf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [spmf_pkg::KIND_BITS-1:0]         kind;
   logic [spmf_pkg::LEVEL_FIELD_BITS-1:0]  level;
   logic [spmf_pkg::DATA_BITS-1:0]         data_in;

   modport source (output valid, kind, level, data_in, input ready);
   modport sink   (input valid, kind, level, data_in, output ready);
endinterface

### hw/rtl/spmf_rsp_if.sv
// Response channel: valid/ready handshake carrying one result transaction.
interface spmf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [spmf_pkg::STATUS_BITS-1:0]  status;
   logic [spmf_pkg::DATA_BITS-1:0]    data_out;
   logic                              all_empty;

   modport source (output valid, status, data_out, all_empty, input ready);
   modport sink   (input valid, status, data_out, all_empty, output ready);
endinterface

### hw/rtl/spmf_front.sv
// Front end: accepts request transactions and classifies them into commands.
module spmf_front (
   input  logic              clock,
   input  logic              reset,
   spmf_req_if.sink          req_if,
   output spmf_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_ready
);

   logic              cmd_valid_ff, cmd_valid_in;
   spmf_pkg::cmd_type cmd_ff, cmd_in;
   logic              req_take;

   // Take a new request whenever the command register is free or drains now
   assign req_if.ready = !cmd_valid_ff || cmd_ready;
   assign req_take     = req_if.valid && req_if.ready;

   // Classify the request: pop, push to a real level, or push to a bad level
   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      if (req_take) begin
         cmd_valid_in = 1'b1;
         cmd_in.level = spmf_pkg::LEVEL_BITS'(req_if.level);
         cmd_in.value = req_if.data_in[spmf_pkg::STORE_BITS-1:0];
         if (req_if.kind == spmf_pkg::KIND_POP) begin
            cmd_in.op = spmf_pkg::OP_POP;
         end else if (int'(req_if.level) < spmf_pkg::LEVELS) begin
            cmd_in.op = spmf_pkg::OP_PUSH;
         end else begin
            cmd_in.op = spmf_pkg::OP_INVALID;
         end
      end
   end

   // Hold the classified command until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd       = cmd_ff;
   assign cmd_valid = cmd_valid_ff;

endmodule

### hw/rtl/spmf_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
module spmf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  spmf_pkg::cmd_type in_cmd,
   input  logic              in_valid,
   output logic              in_ready,
   output spmf_pkg::cmd_type out_cmd,
   output logic              out_valid,
   input  logic              out_ready
);

   spmf_pkg::cmd_type                   entry_ff [spmf_pkg::QUEUE_DEPTH];
   logic [spmf_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [spmf_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [spmf_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic                                push, pop;

   assign in_ready  = count_ff != spmf_pkg::QCNT_BITS'(spmf_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == spmf_pkg::QPTR_BITS'(spmf_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == spmf_pkg::QPTR_BITS'(spmf_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

### hw/rtl/spmf_back.sv
// Back end: per-level rings, priority pop selection and the result register.
module spmf_back (
   input  logic              clock,
   input  logic              reset,
   input  spmf_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   spmf_rsp_if.source        rsp_if
);

   logic [spmf_pkg::STORE_BITS-1:0] ring_store [spmf_pkg::SLOTS];
   logic [spmf_pkg::STORE_BITS-1:0] rd_data_ff;

   logic [spmf_pkg::PTR_BITS-1:0] rd_ptr_ff [spmf_pkg::LEVELS];
   logic [spmf_pkg::PTR_BITS-1:0] rd_ptr_in [spmf_pkg::LEVELS];
   logic [spmf_pkg::PTR_BITS-1:0] wr_ptr_ff [spmf_pkg::LEVELS];
   logic [spmf_pkg::PTR_BITS-1:0] wr_ptr_in [spmf_pkg::LEVELS];
   logic [spmf_pkg::CNT_BITS-1:0] fill_ff   [spmf_pkg::LEVELS];
   logic [spmf_pkg::CNT_BITS-1:0] fill_in   [spmf_pkg::LEVELS];

   logic                       res_valid_ff, res_valid_in;
   spmf_pkg::status_type       status_ff, status_in;
   logic                       pop_ok_ff, pop_ok_in;
   logic                       all_empty_ff, all_empty_in;

   logic                              take;
   logic                              found;
   logic [spmf_pkg::LEVEL_BITS-1:0]   pop_lvl;
   logic [spmf_pkg::LEVEL_BITS-1:0]   lvl;
   logic [spmf_pkg::PTR_BITS-1:0]     slot_ptr;
   logic [spmf_pkg::ADDR_BITS-1:0]    addr;
   logic                              mem_we, mem_re;

   // Take a command when the result register is free or drains now
   assign cmd_ready = !res_valid_ff || rsp_if.ready;
   assign take      = cmd_valid && cmd_ready;

   // Pick the highest non-empty level
   always_comb begin
      found   = 1'b0;
      pop_lvl = '0;
      for (int l = 0; l < spmf_pkg::LEVELS; l++) begin
         if (fill_ff[l] != '0) begin
            found   = 1'b1;
            pop_lvl = spmf_pkg::LEVEL_BITS'(l);
         end
      end
   end

   // Carry out the command against the ring state
   always_comb begin
      for (int l = 0; l < spmf_pkg::LEVELS; l++) begin
         rd_ptr_in[l] = rd_ptr_ff[l];
         wr_ptr_in[l] = wr_ptr_ff[l];
         fill_in[l]   = fill_ff[l];
      end
      status_in = spmf_pkg::ST_DONE;
      pop_ok_in = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      lvl       = cmd.level;
      slot_ptr  = wr_ptr_ff[cmd.level];
      case (cmd.op)
         spmf_pkg::OP_PUSH: begin
            if (fill_ff[cmd.level] == spmf_pkg::CNT_BITS'(spmf_pkg::DEPTH)) begin
               status_in = spmf_pkg::ST_FULL;
            end else begin
               mem_we = take;
               wr_ptr_in[cmd.level] =
                  (wr_ptr_ff[cmd.level] == spmf_pkg::PTR_BITS'(spmf_pkg::DEPTH - 1))
                  ? '0 : wr_ptr_ff[cmd.level] + 1'b1;
               fill_in[cmd.level] = fill_ff[cmd.level] + 1'b1;
            end
         end
         spmf_pkg::OP_POP: begin
            lvl      = pop_lvl;
            slot_ptr = rd_ptr_ff[pop_lvl];
            if (found) begin
               mem_re    = take;
               pop_ok_in = 1'b1;
               rd_ptr_in[pop_lvl] =
                  (rd_ptr_ff[pop_lvl] == spmf_pkg::PTR_BITS'(spmf_pkg::DEPTH - 1))
                  ? '0 : rd_ptr_ff[pop_lvl] + 1'b1;
               fill_in[pop_lvl] = fill_ff[pop_lvl] - 1'b1;
            end else begin
               status_in = spmf_pkg::ST_EMPTY;
            end
         end
         spmf_pkg::OP_INVALID: begin
            status_in = spmf_pkg::ST_INVALID;
         end
         default: begin
            status_in = spmf_pkg::ST_INVALID;
         end
      endcase
      addr = spmf_pkg::ADDR_BITS'(lvl) * spmf_pkg::ADDR_BITS'(spmf_pkg::DEPTH)
             + spmf_pkg::ADDR_BITS'(slot_ptr);
      all_empty_in = 1'b1;
      for (int l = 0; l < spmf_pkg::LEVELS; l++) begin
         if (fill_in[l] != '0) begin
            all_empty_in = 1'b0;
         end
      end
   end

   // Load the result on a take, drop it once the receiver has it
   always_comb begin
      if (take) begin
         res_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   // Ring pointers, fill counts and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < spmf_pkg::LEVELS; l++) begin
            rd_ptr_ff[l] <= '0;
            wr_ptr_ff[l] <= '0;
            fill_ff[l]   <= '0;
         end
         res_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            for (int l = 0; l < spmf_pkg::LEVELS; l++) begin
               rd_ptr_ff[l] <= rd_ptr_in[l];
               wr_ptr_ff[l] <= wr_ptr_in[l];
               fill_ff[l]   <= fill_in[l];
            end
         end
         res_valid_ff <= res_valid_in;
      end
   end

   // Result payload, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff    <= status_in;
         pop_ok_ff    <= pop_ok_in;
         all_empty_ff <= all_empty_in;
      end
   end

   // Ring storage: one write or one registered read per command
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_store[addr] <= cmd.value;
      end
      if (mem_re) begin
         rd_data_ff <= ring_store[addr];
      end
   end

   assign rsp_if.valid     = res_valid_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.data_out  = pop_ok_ff ? spmf_pkg::DATA_BITS'(rd_data_ff) : '0;
   assign rsp_if.all_empty = all_empty_ff;

endmodule

### hw/rtl/strict_priority_multi_fifo.sv
// Top level of the strict priority queue with one FIFO ring per level.
//
// Usage:
//   req_if carries one transaction per push or pop: kind 0 pushes data_in at
//   level, kind 1 pops the oldest value of the highest non-empty level.
//   rsp_if returns exactly one result per request, in request order: status
//   (done, level full, invalid level, all empty), the popped value or zero,
//   and whether every ring is empty after that request.
//   A request passes from accept to response valid through the front
//   classifier register, the command queue, then the back end that updates
//   the ring and loads the result register.
//   Throughput is one request per cycle while rsp_if.ready holds; the back
//   end owns all ring state and a pop reads the ring storage through its
//   registered read port. Reset clears pointers, fill counts and all valid
//   flags; ring contents are left as they are and are only read after being
//   written. A stalled response holds in the result register; the command
//   queue and the front register then fill and req_if.ready drops after
//   three more requests.
module strict_priority_multi_fifo (
   input  logic       clock,
   input  logic       reset,
   spmf_req_if.sink   req_if,
   spmf_rsp_if.source rsp_if
);

   spmf_pkg::cmd_type front_cmd, back_cmd;
   logic              front_valid, front_ready;
   logic              back_valid, back_ready;

   spmf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   spmf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (back_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   spmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp_if    (rsp_if)
   );

endmodule

### hw/rtl/spmf_checker.sv
// Port-level checks of the priority queue and their bind to the top level.
`include "strict_priority_multi_fifo_defines.svh"

module spmf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [spmf_pkg::STATUS_BITS-1:0] rsp_status,
   input logic [spmf_pkg::DATA_BITS-1:0]   rsp_data_out,
   input logic                             rsp_all_empty
);

   logic [spmf_pkg::STATUS_BITS+spmf_pkg::DATA_BITS:0] rsp_payload;

   // Gather the response fields for the hold check
   assign rsp_payload = {rsp_status, rsp_data_out, rsp_all_empty};

   // A stalled response holds its payload
   `SPMF_ASSERT_NXT(rsp_hold_chk, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // Only a response with status done may carry a nonzero value
   `SPMF_ASSERT_IMP(data_zero_chk, rsp_valid && rsp_status != spmf_pkg::ST_DONE, rsp_data_out == '0)

   // An empty pop leaves every ring empty
   `SPMF_ASSERT_IMP(empty_flag_chk, rsp_valid && rsp_status == spmf_pkg::ST_EMPTY, rsp_all_empty)

   // A full level means at least one ring holds data
   `SPMF_ASSERT_IMP(full_flag_chk, rsp_valid && rsp_status == spmf_pkg::ST_FULL, !rsp_all_empty)

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_data_out  (rsp_if.data_out),
   .rsp_all_empty (rsp_if.all_empty)
);
